// ===== design/srp_pkg.sv =====
// shared types and constants for the skyline rectangle packer
package srp_pkg;

	// width of every request and result field
	localparam int FIELD_W = 11;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_CLEAR,
		PH_IDLE,
		PH_BACK,
		PH_TURN,
		PH_FWD,
		PH_DRAIN,
		PH_DECIDE,
		PH_WRITE,
		PH_DONE
	} phase_t;

endpackage

// ===== design/srp_ram.sv =====
// generic simple dual port ram with registered read
module srp_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/skyline_rect_packer.sv =====
// skyline rectangle packer top level
// operation: an accepted word runs a backward and a forward pass over the column heights, then
//   writes the raised columns when placed; a word that is too wide goes straight to the result
// throughput: one request at a time; a new word is not accepted until the result is loaded
// reset: after arst_n releases, a clearing pass zeroes the column heights and holds rect_stall high
module skyline_rect_packer
	import srp_pkg::*;
#(
	parameter int ATLAS_SIZE = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rect_valid,
	output logic               rect_stall,
	input  logic [FIELD_W-1:0] rect_width,
	input  logic [FIELD_W-1:0] rect_height,
	output logic               place_valid,
	input  logic               place_stall,
	output logic               fits,
	output logic [FIELD_W-1:0] placed_x,
	output logic [FIELD_W-1:0] placed_y,
	output logic [FIELD_W-1:0] right_x,
	output logic [FIELD_W-1:0] bottom_y
);

	localparam int N  = ATLAS_SIZE;
	localparam int AW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int HW = (CW < FIELD_W) ? CW : FIELD_W;
	localparam int XW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

	phase_t phase_q, phase_d;

	logic [AW-1:0]      cnt_q;
	logic [AW-1:0]      bpos_q;
	logic               start_q;
	logic [AW-1:0]      wa_q;
	logic [FIELD_W-1:0] h_q;
	logic [HW-1:0]      run_max_q;
	logic [CW-1:0]      best_y_q;
	logic [AW-1:0]      best_x_q;
	logic               fit_q;
	logic [HW-1:0]      wval_q;
	logic               out_valid_q;
	logic               fits_q;
	logic [FIELD_W-1:0] placed_x_q, placed_y_q, right_x_q, bottom_y_q;

	// read stage registers
	logic          v_s1, back_s1, edge_s1, win_s1;
	logic [AW-1:0] addr_s1, idx_s1;

	// memory ports
	logic          h_we, s_we;
	logic [AW-1:0] h_waddr, h_raddr, s_waddr, s_raddr;
	logic [HW-1:0] h_wdata, h_rdata, s_wdata, s_rdata;

	logic          in_acc, too_wide, load_out;
	logic [HW-1:0] new_max, win_max;
	logic          win_better;
	logic          fit_now;
	logic [XW-1:0] px_x, py_x, rx_x, by_x;

	assign in_acc   = rect_valid && !rect_stall;
	assign too_wide = XW'(rect_width) >= XW'(N);

	// column heights
	srp_ram #(.WIDTH(HW), .DEPTH(N)) u_height_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// suffix maxima within blocks of window length
	srp_ram #(.WIDTH(HW), .DEPTH(N)) u_suffix_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// running max over the current block and window max
	always_comb begin
		new_max = (edge_s1 || h_rdata > run_max_q) ? h_rdata : run_max_q;
		win_max = (s_rdata > new_max) ? s_rdata : new_max;
		win_better = CW'(win_max) < best_y_q;
	end

	// placement arithmetic from the best window
	always_comb begin
		px_x    = XW'(best_x_q) + XW'(1);
		py_x    = XW'(best_y_q) + XW'(1);
		rx_x    = px_x + XW'(wa_q);
		by_x    = py_x + XW'(h_q);
		fit_now = XW'(best_y_q) + XW'(h_q) + XW'(1) <= XW'(N);
	end

	// memory access control
	always_comb begin
		h_raddr = cnt_q;
		s_raddr = cnt_q - wa_q;
		s_we    = v_s1 && back_s1;
		s_waddr = addr_s1;
		s_wdata = new_max;
		h_we    = 1'b0;
		h_waddr = cnt_q;
		h_wdata = '0;
		if (phase_q == PH_CLEAR) begin
			h_we = 1'b1;
		end else if (phase_q == PH_WRITE) begin
			h_we    = 1'b1;
			h_waddr = AW'(px_x) + cnt_q;
			h_wdata = wval_q;
		end
	end

	assign load_out = !out_valid_q || !place_stall;

	// next phase
	always_comb begin
		phase_d    = phase_q;
		rect_stall = 1'b1;
		unique case (phase_q)
			PH_CLEAR: begin
				if (cnt_q == AW'(N - 1)) phase_d = PH_IDLE;
			end
			PH_IDLE: begin
				rect_stall = 1'b0;
				if (rect_valid) phase_d = too_wide ? PH_DONE : PH_BACK;
			end
			PH_BACK: begin
				if (cnt_q == '0) phase_d = PH_TURN;
			end
			PH_TURN: begin
				phase_d = PH_FWD;
			end
			PH_FWD: begin
				if (cnt_q == AW'(N - 1)) phase_d = PH_DRAIN;
			end
			PH_DRAIN: begin
				phase_d = PH_DECIDE;
			end
			PH_DECIDE: begin
				phase_d = (fit_now && wa_q != '0) ? PH_WRITE : PH_DONE;
			end
			PH_WRITE: begin
				if (cnt_q == wa_q - AW'(1)) phase_d = PH_DONE;
			end
			PH_DONE: begin
				if (load_out) phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_CLEAR;
			end
		endcase
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLEAR;
		end else begin
			phase_q <= phase_d;
		end
	end

	// position and block counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bpos_q  <= '0;
			start_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
				end
				PH_IDLE: begin
					cnt_q  <= AW'(N - 1);
					bpos_q <= '0;
				end
				PH_BACK: begin
					if (cnt_q != '0) begin
						cnt_q  <= cnt_q - AW'(1);
						bpos_q <= (bpos_q == wa_q) ? '0 : bpos_q + AW'(1);
					end
				end
				PH_TURN: begin
					start_q <= 1'b1;
				end
				PH_FWD: begin
					cnt_q   <= cnt_q + AW'(1);
					start_q <= (bpos_q == '0);
					bpos_q  <= (bpos_q == '0) ? wa_q : bpos_q - AW'(1);
				end
				PH_DECIDE: begin
					cnt_q <= '0;
				end
				PH_WRITE: begin
					cnt_q <= cnt_q + AW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (phase_q == PH_BACK) || (phase_q == PH_FWD);
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		back_s1 <= (phase_q == PH_BACK);
		edge_s1 <= (phase_q == PH_BACK) ? (bpos_q == '0) : start_q;
		win_s1  <= (phase_q == PH_FWD) && (cnt_q >= wa_q);
		addr_s1 <= cnt_q;
		idx_s1  <= cnt_q - wa_q;
	end

	// request capture, block max and best window tracking
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wa_q  <= AW'(rect_width);
			h_q   <= rect_height;
			fit_q <= 1'b0;
		end
		if (v_s1) begin
			run_max_q <= new_max;
		end
		if (phase_q == PH_TURN) begin
			best_y_q <= CW'(N);
			best_x_q <= '0;
		end else if (v_s1 && !back_s1 && win_s1 && win_better) begin
			best_y_q <= CW'(win_max);
			best_x_q <= idx_s1;
		end
		if (phase_q == PH_DECIDE) begin
			fit_q  <= fit_now;
			wval_q <= HW'(by_x);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (phase_q == PH_DONE && load_out) begin
			out_valid_q <= 1'b1;
		end else if (!place_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_DONE && load_out) begin
			fits_q     <= fit_q;
			placed_x_q <= fit_q ? FIELD_W'(px_x) : '0;
			placed_y_q <= fit_q ? FIELD_W'(py_x) : '0;
			right_x_q  <= fit_q ? FIELD_W'(rx_x) : '0;
			bottom_y_q <= fit_q ? FIELD_W'(by_x) : '0;
		end
	end

	assign place_valid = out_valid_q;
	assign fits        = fits_q;
	assign placed_x    = placed_x_q;
	assign placed_y    = placed_y_q;
	assign right_x     = right_x_q;
	assign bottom_y    = bottom_y_q;

`ifndef SYNTH
	// suffix memory is written only while the backward pass drains
	a_suffix_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		s_we |-> (phase_q == PH_BACK || phase_q == PH_TURN))
		else $error("suffix write outside backward pass");

	// raised columns stay inside the atlas
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WRITE |-> (px_x + XW'(cnt_q) < XW'(N)))
		else $error("column write beyond atlas");

	// best window height never exceeds the atlas size
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DECIDE |-> best_y_q <= CW'(N))
		else $error("best window height out of range");

	// an accepted word starts a scan or goes straight to the result
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (phase_q == PH_BACK || phase_q == PH_DONE))
		else $error("accepted word did not start processing");
`endif

endmodule
